// ===== design/audio_eq_limiter_chain_defines.svh =====
// Assertion macros shared by the checker of the equalizer / limiter chain.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef AUDIO_EQ_LIMITER_CHAIN_DEFINES_SVH
`define AUDIO_EQ_LIMITER_CHAIN_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define AELC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aelc: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define AELC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aelc: next-cycle check failed");

`endif

// ===== design/aelc_pkg.sv =====
// Package of the equalizer / limiter chain: widths, constants, codes, helpers.
// Used by the interfaces, the divider, the top level and the checker.
package aelc_pkg;

  localparam int COEF_DEPTH_DEF  = 32;
  localparam int NUM_BIQUADS_DEF = 6;

  localparam int SIG_W     = 32;
  localparam int GAIN_W    = 25;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PCM_W     = 16;
  localparam int CIDX_W    = 5;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int WIDE_W    = 48;

  localparam logic [GAIN_W-1:0] UNITY_GAIN    = 25'd16777216;
  localparam logic [GAIN_W-1:0] MIN_GAIN_STEP = 25'd335544;
  localparam logic [CIDX_W-1:0] DC_POLE_WORD  = 5'd30;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_PROCESS  = 2'd0,
    OP_COEF_WR  = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUNCH_MIX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_COEF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_REL   = 3'd7;

  // Stage enable bits
  localparam int EN_HP     = 0;
  localparam int EN_BASS   = 1;
  localparam int EN_TREBLE = 2;
  localparam int EN_PUNCH  = 3;
  localparam int EN_ACTIVE = 4;

  // Biquad slots
  localparam logic [2:0] BQ_HP0     = 3'd0;
  localparam logic [2:0] BQ_HP1     = 3'd1;
  localparam logic [2:0] BQ_BASS    = 3'd2;
  localparam logic [2:0] BQ_TREBLE  = 3'd3;
  localparam logic [2:0] BQ_PUNCH_I = 3'd4;
  localparam logic [2:0] BQ_PUNCH_O = 3'd5;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam logic signed [WIDE_W-1:0] SIG_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SIG_MIN = -48'sh0000_8000_0000;

  // Saturate a wide value to Q4.27
  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (v > SIG_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SIG_MIN) r = 32'sh8000_0000;
    else r = v[SIG_W-1:0];
    return r;
  endfunction

  // Absolute value, saturated to Q4.27
  function automatic logic signed [SIG_W-1:0] abs_sat(input logic signed [SIG_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (v == 32'sh8000_0000) r = 32'sh7FFF_FFFF;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

endpackage

// ===== design/aelc_if.sv =====
// Valid / ready channels of the equalizer / limiter chain.
// Depends on aelc_pkg for the field widths.
interface aelc_in_if import aelc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [PCM_W-1:0]  sample_in;
  logic                     block_end;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [SIG_W-1:0]  coef_value;

  modport source (output valid, op, sample_in, block_end, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, op, sample_in, block_end, coef_index, coef_value,
                  output ready);
endinterface

interface aelc_out_if import aelc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PCM_W-1:0]  sample_out;
  logic [GAIN_W-1:0]        limiter_gain;
  logic [GAIN_W-1:0]        block_min_gain;

  modport source (output valid, sample_out, limiter_gain, block_min_gain, input ready);
  modport sink   (input valid, sample_out, limiter_gain, block_min_gain, output ready);
endinterface

// ===== design/aelc_div.sv =====
// Restoring divider for the limiter target gain: thr * 2^27 / det, one bit a cycle.
// Depends on aelc_pkg; the caller guarantees det > thr * 8, so the quotient fits 25 bits.
module aelc_div import aelc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CFG_W-1:0]    thr_i,
  input  logic [SIG_W-1:0]    det_i,
  output logic [GAIN_W-1:0]   quo_o,
  output div_status_t         status_o
);

  logic [SIG_W:0]     rem_q, rem_d, rem_sh;
  logic [SIG_W-1:0]   det_q;
  logic [GAIN_W-1:0]  quo_q, quo_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               fits;

  // One trial subtraction per cycle
  assign rem_sh = {rem_q[SIG_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, det_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      // upper dividend bits reduce to thr * 4, lower 25 bits are zero
      rem_d  = (SIG_W+1)'({thr_i, 2'b00});
      quo_d  = '0;
      cnt_d  = 5'(GAIN_W);
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != 5'd0) begin
      rem_d = fits ? rem_sh - {1'b0, det_q} : rem_sh;
      quo_d = {quo_q[GAIN_W-2:0], fits};
      cnt_d = cnt_q - 5'd1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) det_q <= det_i;
  end

  assign quo_o           = quo_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = busy_q && (cnt_q == 5'd0);

endmodule

// ===== design/audio_eq_limiter_chain.sv =====
// Top level of the equalizer / limiter chain: sequencer around one shared multiplier.
// Depends on aelc_pkg, aelc_if and aelc_div.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | op, sample_in, block_end, coef_index, coef_value
//  out_ch   | out | valid / ready | sample_out, limiter_gain, block_min_gain
//  cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// A processed sample runs through the enabled stages in turn: each multiply runs on
// the shared multiplier in phases (operand load, product, accumulate), each biquad
// takes five multiplies, the gain division runs on the divider, and a new detector peak
// skips its decay multiply. Coefficient writes, history clears and passthrough samples
// skip the filter states. Reset clears the history and sets gains and registers to their
// defaults; no clearing pass. A stalled output holds in its register while the sequencer
// finishes and then waits.
module audio_eq_limiter_chain import aelc_pkg::*; #(
  parameter int COEF_DEPTH  = COEF_DEPTH_DEF,
  parameter int NUM_BIQUADS = NUM_BIQUADS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aelc_in_if.sink               in_ch,
  aelc_out_if.source            out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int AW      = $clog2(COEF_DEPTH);
  localparam int HDEPTH  = 4 * NUM_BIQUADS;
  localparam int HW      = $clog2(HDEPTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DC   = 4'd1;
  localparam logic [3:0] S_BQ   = 4'd2;
  localparam logic [3:0] S_ENV  = 4'd3;
  localparam logic [3:0] S_PMIX = 4'd4;
  localparam logic [3:0] S_MIX  = 4'd5;
  localparam logic [3:0] S_PEAK = 4'd6;
  localparam logic [3:0] S_TGT  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_GAIN = 4'd9;
  localparam logic [3:0] S_OUT1 = 4'd10;
  localparam logic [3:0] S_OUT2 = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  // Multiply phases
  localparam logic [1:0] P_LOAD = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_USE  = 2'd2;

  // Configuration registers
  logic [4:0]        en_q;
  logic [CFG_W-1:0]  mix_q, thr_q, makeup_q, env_coef_q, attack_q, release_q, det_rel_q;

  // Coefficient memory and filter state
  logic signed [SIG_W-1:0]  coef_mem [COEF_DEPTH];
  logic signed [SIG_W-1:0]  coef_q;
  logic [AW-1:0]            coef_rd_addr;
  logic signed [SIG_W-1:0]  hist_q [HDEPTH];
  logic signed [SIG_W-1:0]  dc_in_q, dc_out_q, env_q, peak_q;
  logic [GAIN_W-1:0]        gain_q, held_q, run_q, target_q;
  logic                     open_q, last_q;

  // Sequencer and datapath registers
  logic [3:0]               state_q;
  logic [1:0]               phase_q;
  logic [2:0]               bq_q, tap_q;
  logic signed [SIG_W-1:0]  x_q, h_q, bq_in_q, tmp_q;
  logic signed [WIDE_W-1:0] acc_q;
  logic signed [MUL_A_W-1:0] mul_a_q, mul_a_sel;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  // Result and output registers
  logic signed [PCM_W-1:0]  res_smp_q, out_smp_q;
  logic [GAIN_W-1:0]        res_gain_q, res_min_q, out_gain_q, out_min_q;
  logic                     out_valid_q;

  logic                     in_fire, is_mul, div_start, peak_up;
  logic [GAIN_W-1:0]        div_quo;
  div_status_t              div_st;
  logic [HW-1:0]            hidx, hbase;
  logic signed [SIG_W-1:0]  hist_rd, abs_x, y_bq;
  logic signed [WIDE_W-1:0] p27, p24, p20, acc_new, env_new, gain_new, tgt_diff;
  logic signed [55:0]       scl, ydiv;
  logic signed [PCM_W-1:0]  y_pcm;
  logic [GAIN_W-1:0]        run_start;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_mul      = state_q inside {S_DC, S_BQ, S_ENV, S_PMIX, S_PEAK, S_GAIN,
                                       S_OUT1, S_OUT2};

  // History addressing for the current biquad tap
  assign hbase   = HW'(32'(bq_q) * 4);
  assign hidx    = HW'(32'(bq_q) * 4 + 32'(tap_q) - 1);
  assign hist_rd = hist_q[hidx];

  // Coefficient read address
  always_comb begin
    if (state_q == S_DC) coef_rd_addr = AW'(DC_POLE_WORD);
    else coef_rd_addr = AW'(32'(bq_q) * 5 + 32'(tap_q));
  end

  // Write coefficient words and read the selected one
  always_ff @(posedge clk_i) begin
    if (in_fire && in_ch.op == OP_COEF_WR && 32'(in_ch.coef_index) < COEF_DEPTH)
      coef_mem[AW'(in_ch.coef_index)] <= in_ch.coef_value;
    coef_q <= coef_mem[coef_rd_addr];
  end

  assign abs_x    = abs_sat(x_q);
  assign peak_up  = abs_x > peak_q;
  assign tgt_diff = WIDE_W'($signed({1'b0, target_q})) - WIDE_W'($signed({1'b0, gain_q}));

  // Select the first multiplier operand
  always_comb begin
    case (state_q)
      S_DC:    mul_a_sel = MUL_A_W'(dc_out_q);
      S_BQ:    mul_a_sel = (tap_q == 3'd0) ? MUL_A_W'(bq_in_q) : MUL_A_W'(hist_rd);
      S_ENV:   mul_a_sel = MUL_A_W'(WIDE_W'(tmp_q) - WIDE_W'(env_q));
      S_PMIX:  mul_a_sel = MUL_A_W'(tmp_q);
      S_PEAK:  mul_a_sel = MUL_A_W'(WIDE_W'(abs_x) - WIDE_W'(peak_q));
      S_GAIN:  mul_a_sel = MUL_A_W'(tgt_diff);
      S_OUT1:  mul_a_sel = MUL_A_W'(x_q);
      S_OUT2:  mul_a_sel = MUL_A_W'(tmp_q);
      default: mul_a_sel = '0;
    endcase
  end

  // Select the second multiplier operand
  always_comb begin
    case (state_q)
      S_DC, S_BQ: mul_b = MUL_B_W'(coef_q);
      S_ENV:      mul_b = $signed({9'b0, env_coef_q});
      S_PMIX:     mul_b = $signed({9'b0, mix_q});
      S_PEAK:     mul_b = $signed({9'b0, det_rel_q});
      S_GAIN:     mul_b = (target_q < gain_q) ? $signed({9'b0, attack_q})
                                              : $signed({9'b0, release_q});
      S_OUT1:     mul_b = $signed({8'b0, gain_q});
      S_OUT2:     mul_b = $signed({9'b0, makeup_q});
      default:    mul_b = '0;
    endcase
  end

  // Shared multiplier
  assign prod_d = mul_a_q * mul_b;

  // Floored products in each format
  assign p27 = WIDE_W'(prod_q >>> 27);
  assign p24 = WIDE_W'(prod_q >>> 24);
  assign p20 = WIDE_W'(prod_q >>> 20);

  // Biquad accumulation: feed-forward taps add, feedback taps subtract
  always_comb begin
    if (tap_q == 3'd0) acc_new = p27;
    else if (tap_q < 3'd3) acc_new = acc_q + p27;
    else acc_new = acc_q - p27;
  end
  assign y_bq = sat32(acc_new);

  assign env_new  = WIDE_W'(env_q) + p24;
  assign gain_new = WIDE_W'($signed({1'b0, gain_q})) + p24;

  // Scale to PCM: times 32767, divide by 2^27 toward zero, saturate
  assign scl  = (56'(p20) <<< 15) - 56'(p20);
  assign ydiv = (scl < 0) ? (scl + 56'sd134217727) >>> 27 : scl >>> 27;
  always_comb begin
    if (ydiv > 56'sd32767) y_pcm = 16'sh7FFF;
    else if (ydiv < -56'sd32768) y_pcm = 16'sh8000;
    else y_pcm = ydiv[PCM_W-1:0];
  end

  assign run_start = (held_q + MIN_GAIN_STEP > UNITY_GAIN) ? UNITY_GAIN
                                                           : held_q + MIN_GAIN_STEP;
  assign div_start = (state_q == S_TGT) && (peak_q > $signed({5'b0, thr_q, 3'b000}));

  aelc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .thr_i    (thr_q),
    .det_i    (peak_q),
    .quo_o    (div_quo),
    .status_o (div_st)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= '0;
      mix_q      <= '0;
      thr_q      <= 24'd15938355;
      makeup_q   <= 24'd1048576;
      env_coef_q <= '0;
      attack_q   <= '0;
      release_q  <= '0;
      det_rel_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLES:   en_q       <= cfg_data_i[4:0];
        CFG_PUNCH_MIX: mix_q      <= cfg_data_i;
        CFG_THRESHOLD: thr_q      <= cfg_data_i;
        CFG_MAKEUP:    makeup_q   <= cfg_data_i;
        CFG_ENV_COEF:  env_coef_q <= cfg_data_i;
        CFG_ATTACK:    attack_q   <= cfg_data_i;
        CFG_RELEASE:   release_q  <= cfg_data_i;
        CFG_DET_REL:   det_rel_q  <= cfg_data_i;
        default:       en_q       <= en_q;
      endcase
    end
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_LOAD;
      bq_q        <= '0;
      tap_q       <= '0;
      for (int i = 0; i < HDEPTH; i++) hist_q[i] <= '0;
      dc_in_q     <= '0;
      dc_out_q    <= '0;
      env_q       <= '0;
      peak_q      <= '0;
      gain_q      <= UNITY_GAIN;
      held_q      <= UNITY_GAIN;
      run_q       <= UNITY_GAIN;
      target_q    <= UNITY_GAIN;
      open_q      <= 1'b0;
      last_q      <= 1'b0;
      x_q         <= '0;
      h_q         <= '0;
      bq_in_q     <= '0;
      tmp_q       <= '0;
      acc_q       <= '0;
      mul_a_q     <= '0;
      prod_q      <= '0;
      res_smp_q   <= '0;
      res_gain_q  <= '0;
      res_min_q   <= '0;
      out_valid_q <= 1'b0;
      out_smp_q   <= '0;
      out_gain_q  <= '0;
      out_min_q   <= '0;
    end else begin
      // drop the output once it is taken, unless a new result replaces it
      if (out_valid_q && out_ch.ready && state_q != S_EMIT) out_valid_q <= 1'b0;

      if (is_mul && phase_q == P_LOAD) begin
        if (state_q == S_PEAK && peak_up) begin
          // new peak: jump, no decay multiply
          peak_q  <= abs_x;
          state_q <= S_TGT;
        end else begin
          mul_a_q <= mul_a_sel;
          phase_q <= P_MUL;
        end
      end else if (is_mul && phase_q == P_MUL) begin
        prod_q  <= prod_d;
        phase_q <= P_USE;
      end else begin
        phase_q <= P_LOAD;
        case (state_q)
          S_IDLE: begin
            if (in_fire) begin
              case (in_ch.op)
                OP_PROCESS: begin
                  if (en_q[EN_ACTIVE]) begin
                    if (!open_q) begin
                      run_q  <= run_start;
                      open_q <= 1'b1;
                    end
                    x_q     <= SIG_W'(in_ch.sample_in) <<< 12;
                    h_q     <= '0;
                    last_q  <= in_ch.block_end;
                    state_q <= S_DC;
                  end else begin
                    res_smp_q  <= in_ch.sample_in;
                    res_gain_q <= gain_q;
                    res_min_q  <= held_q;
                    state_q    <= S_EMIT;
                  end
                end
                OP_CLEAR: begin
                  for (int i = 0; i < HDEPTH; i++) hist_q[i] <= '0;
                  dc_in_q  <= '0;
                  dc_out_q <= '0;
                  env_q    <= '0;
                  peak_q   <= '0;
                  gain_q   <= UNITY_GAIN;
                  held_q   <= UNITY_GAIN;
                  run_q    <= UNITY_GAIN;
                  open_q   <= 1'b0;
                end
                default: state_q <= S_IDLE;
              endcase
            end
          end
          S_DC: begin
            dc_in_q  <= x_q;
            dc_out_q <= sat32(WIDE_W'(x_q) - WIDE_W'(dc_in_q) + p27);
            x_q      <= sat32(WIDE_W'(x_q) - WIDE_W'(dc_in_q) + p27);
            bq_in_q  <= sat32(WIDE_W'(x_q) - WIDE_W'(dc_in_q) + p27);
            tap_q    <= '0;
            if (en_q[EN_PUNCH]) begin
              bq_q <= BQ_PUNCH_I; state_q <= S_BQ;
            end else if (en_q[EN_HP]) begin
              bq_q <= BQ_HP0; state_q <= S_BQ;
            end else begin
              state_q <= S_MIX;
            end
          end
          S_BQ: begin
            acc_q <= acc_new;
            if (tap_q != 3'd4) begin
              tap_q <= tap_q + 3'd1;
            end else begin
              // shift the history of this section
              hist_q[hbase + HW'(1)] <= hist_q[hbase];
              hist_q[hbase]          <= bq_in_q;
              hist_q[hbase + HW'(3)] <= hist_q[hbase + HW'(2)];
              hist_q[hbase + HW'(2)] <= y_bq;
              tap_q <= '0;
              case (bq_q)
                BQ_HP0: begin
                  bq_in_q <= y_bq; bq_q <= BQ_HP1;
                end
                BQ_HP1: begin
                  x_q <= y_bq; state_q <= S_MIX;
                end
                BQ_BASS: begin
                  x_q <= y_bq; bq_in_q <= y_bq;
                  if (en_q[EN_TREBLE]) bq_q <= BQ_TREBLE;
                  else state_q <= S_PEAK;
                end
                BQ_PUNCH_I: begin
                  tmp_q <= abs_sat(y_bq); state_q <= S_ENV;
                end
                BQ_PUNCH_O: begin
                  tmp_q <= y_bq; state_q <= S_PMIX;
                end
                default: begin
                  x_q <= y_bq; state_q <= S_PEAK;
                end
              endcase
            end
          end
          S_ENV: begin
            env_q   <= env_new[SIG_W-1:0];
            bq_in_q <= sat32(WIDE_W'(tmp_q) - env_new);
            bq_q    <= BQ_PUNCH_O;
            tap_q   <= '0;
            state_q <= S_BQ;
          end
          S_PMIX: begin
            h_q   <= sat32(p20);
            tap_q <= '0;
            if (en_q[EN_HP]) begin
              bq_in_q <= x_q; bq_q <= BQ_HP0; state_q <= S_BQ;
            end else begin
              state_q <= S_MIX;
            end
          end
          S_MIX: begin
            x_q     <= sat32(WIDE_W'(x_q) + WIDE_W'(h_q));
            bq_in_q <= sat32(WIDE_W'(x_q) + WIDE_W'(h_q));
            tap_q   <= '0;
            if (en_q[EN_BASS]) begin
              bq_q <= BQ_BASS; state_q <= S_BQ;
            end else if (en_q[EN_TREBLE]) begin
              bq_q <= BQ_TREBLE; state_q <= S_BQ;
            end else begin
              state_q <= S_PEAK;
            end
          end
          S_PEAK: begin
            peak_q  <= sat32(WIDE_W'(peak_q) + p24);
            state_q <= S_TGT;
          end
          S_TGT: begin
            if (div_start) begin
              state_q <= S_DIV;
            end else begin
              target_q <= UNITY_GAIN;
              state_q  <= S_GAIN;
            end
          end
          S_DIV: begin
            if (div_st.done) begin
              target_q <= div_quo;
              state_q  <= S_GAIN;
            end
          end
          S_GAIN: begin
            gain_q <= gain_new[GAIN_W-1:0];
            if (gain_new < WIDE_W'($signed({1'b0, run_q}))) run_q <= gain_new[GAIN_W-1:0];
            state_q <= S_OUT1;
          end
          S_OUT1: begin
            tmp_q   <= p24[SIG_W-1:0];
            state_q <= S_OUT2;
          end
          S_OUT2: begin
            res_smp_q  <= y_pcm;
            res_gain_q <= gain_q;
            res_min_q  <= run_q;
            if (last_q) begin
              held_q <= run_q;
              open_q <= 1'b0;
            end
            state_q <= S_EMIT;
          end
          S_EMIT: begin
            // hold until the output register is free
            if (!out_valid_q || out_ch.ready) begin
              out_valid_q <= 1'b1;
              out_smp_q   <= res_smp_q;
              out_gain_q  <= res_gain_q;
              out_min_q   <= res_min_q;
              state_q     <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.sample_out     = out_smp_q;
  assign out_ch.limiter_gain   = out_gain_q;
  assign out_ch.block_min_gain = out_min_q;

endmodule

// ===== design/aelc_checker.sv =====
// Port-level checker of the equalizer / limiter chain, bound to the top level.
// Depends on aelc_pkg and the assertion macros header.
`include "audio_eq_limiter_chain_defines.svh"

module aelc_checker import aelc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         op,
  input logic               out_valid,
  input logic               out_ready,
  input logic [GAIN_W-1:0]  limiter_gain,
  input logic [GAIN_W-1:0]  block_min_gain
);

  // a pending result stays offered
  `AELC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // gains never exceed unity
  `AELC_ASSERT_NOW(a_gain_range, out_valid, limiter_gain <= UNITY_GAIN && block_min_gain <= UNITY_GAIN)

  // the block is not ready in the cycle after a sample transfer
  `AELC_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && op == OP_PROCESS, !in_ready)

  // coefficient writes, clears and reserved ops produce no result
  `AELC_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && op != OP_PROCESS && !out_valid, !out_valid)

endmodule

bind audio_eq_limiter_chain aelc_checker u_aelc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .op             (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .limiter_gain   (out_ch.limiter_gain),
  .block_min_gain (out_ch.block_min_gain)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for audio_eq_limiter_chain: directed and random sample streams
// against a cycle-free fixed-point model of the filter and limiter chain.
// Depends on aelc_pkg and the aelc_in_if / aelc_out_if interfaces.
module tb;
  import aelc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [PCM_W-1:0] pcm;
    logic [GAIN_W-1:0]       gain;
    logic [GAIN_W-1:0]       min_gain;
  } chain_out_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  aelc_in_if  in_ch ();
  aelc_out_if out_ch ();

  audio_eq_limiter_chain dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the chain state
  logic signed [SIG_W-1:0] coef_words [32];
  logic signed [SIG_W-1:0] bq_hist [24];
  longint dc_in_prev, dc_out_prev, env_level, peak_level;
  longint gain_smooth, gain_held, gain_run_min;
  bit blk_open;
  logic [4:0] m_enables;
  longint m_mix, m_thr, m_makeup, m_env_c, m_atk, m_rel, m_det_rel;

  chain_out_t expected_outputs[$];
  int errors, n_samples, n_results, n_cfg_writes, n_coef_writes;
  bit no_idle;
  int hold_request, hold_taken;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_q427(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs_q427(longint v);
    return sat_q427(v < 0 ? -v : v);
  endfunction

  function automatic longint coef_at(int i);
    longint c;
    c = coef_words[i];
    return c;
  endfunction

  function automatic longint hist_at(int i);
    longint h;
    h = bq_hist[i];
    return h;
  endfunction

  function automatic longint run_biquad(int k, longint x);
    int c;
    int h;
    longint acc;
    longint y;
    c = 5 * k;
    h = 4 * k;
    acc = ((coef_at(c) * x) >>> 27) + ((coef_at(c + 1) * hist_at(h)) >>> 27)
        + ((coef_at(c + 2) * hist_at(h + 1)) >>> 27)
        - ((coef_at(c + 3) * hist_at(h + 2)) >>> 27)
        - ((coef_at(c + 4) * hist_at(h + 3)) >>> 27);
    y = sat_q427(acc);
    bq_hist[h + 1] = bq_hist[h];
    bq_hist[h] = x[31:0];
    bq_hist[h + 3] = bq_hist[h + 2];
    bq_hist[h + 2] = y[31:0];
    return y;
  endfunction

  function automatic void clear_chain_state();
    foreach (bq_hist[i]) bq_hist[i] = '0;
    dc_in_prev = 0;
    dc_out_prev = 0;
    env_level = 0;
    peak_level = 0;
    gain_smooth = UNITY_GAIN;
    gain_held = UNITY_GAIN;
    gain_run_min = UNITY_GAIN;
    blk_open = 1'b0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    longint v;
    v = d;
    case (idx)
      CFG_ENABLES:   m_enables = d[4:0];
      CFG_PUNCH_MIX: m_mix = v;
      CFG_THRESHOLD: m_thr = v;
      CFG_MAKEUP:    m_makeup = v;
      CFG_ENV_COEF:  m_env_c = v;
      CFG_ATTACK:    m_atk = v;
      CFG_RELEASE:   m_rel = v;
      CFG_DET_REL:   m_det_rel = v;
      default: ;
    endcase
  endfunction

  // Work out the result of one accepted item; returns 1 when a result is due
  function automatic bit chain_predict(logic [1:0] op, logic signed [15:0] pcm, logic last,
                                       logic [4:0] cidx, logic signed [31:0] cval,
                                       output chain_out_t r);
    longint x, dc, h, la, band, a, target, t, y;
    r = '{default: '0};
    if (op == OP_COEF_WR) begin
      coef_words[cidx] = cval;
      return 1'b0;
    end
    if (op == OP_CLEAR) begin
      clear_chain_state();
      return 1'b0;
    end
    if (op != OP_PROCESS) return 1'b0;
    if (!m_enables[EN_ACTIVE]) begin
      r.pcm = pcm;
      r.gain = gain_smooth[24:0];
      r.min_gain = gain_held[24:0];
      return 1'b1;
    end
    if (!blk_open) begin
      gain_run_min = gain_held + MIN_GAIN_STEP;
      if (gain_run_min > UNITY_GAIN) gain_run_min = UNITY_GAIN;
      blk_open = 1'b1;
    end
    x = pcm;
    x = x * 4096;
    dc = sat_q427(x - dc_in_prev + ((coef_at(DC_POLE_WORD) * dc_out_prev) >>> 27));
    dc_in_prev = x;
    dc_out_prev = dc;
    x = dc;
    h = 0;
    if (m_enables[EN_PUNCH]) begin
      la = abs_q427(run_biquad(BQ_PUNCH_I, x));
      env_level += ((la - env_level) * m_env_c) >>> 24;
      band = run_biquad(BQ_PUNCH_O, sat_q427(la - env_level));
      h = sat_q427((band * m_mix) >>> 20);
    end
    if (m_enables[EN_HP]) begin
      x = run_biquad(BQ_HP0, x);
      x = run_biquad(BQ_HP1, x);
    end
    x = sat_q427(x + h);
    if (m_enables[EN_BASS]) x = run_biquad(BQ_BASS, x);
    if (m_enables[EN_TREBLE]) x = run_biquad(BQ_TREBLE, x);
    a = abs_q427(x);
    if (a > peak_level) peak_level = a;
    else peak_level += ((a - peak_level) * m_det_rel) >>> 24;
    target = UNITY_GAIN;
    if (peak_level > m_thr * 8) target = (m_thr * 134217728) / peak_level;
    gain_smooth += ((target - gain_smooth) * (target < gain_smooth ? m_atk : m_rel)) >>> 24;
    if (gain_smooth < gain_run_min) gain_run_min = gain_smooth;
    t = (x * gain_smooth) >>> 24;
    t = (t * m_makeup) >>> 20;
    y = (t * 32767) / 134217728;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.pcm = y[15:0];
    r.gain = gain_smooth[24:0];
    r.min_gain = gain_run_min[24:0];
    if (last) begin
      gain_held = gain_run_min;
      blk_open = 1'b0;
    end
    return 1'b1;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != hold_taken) begin
        hold_taken = hold_request;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    chain_out_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample=%0d gain=%0d min=%0d", $time,
                 out_ch.sample_out, out_ch.limiter_gain, out_ch.block_min_gain);
      end else begin
        e = expected_outputs.pop_front();
        if (out_ch.sample_out !== e.pcm) begin
          errors++;
          $display("%0t: sample_out expected %0d actual %0d", $time, e.pcm,
                   out_ch.sample_out);
        end
        if (out_ch.limiter_gain !== e.gain) begin
          errors++;
          $display("%0t: limiter_gain expected %0d actual %0d", $time, e.gain,
                   out_ch.limiter_gain);
        end
        if (out_ch.block_min_gain !== e.min_gain) begin
          errors++;
          $display("%0t: block_min_gain expected %0d actual %0d", $time, e.min_gain,
                   out_ch.block_min_gain);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the transfer; valid stays high afterwards
  task automatic send_item(logic [1:0] op, logic signed [15:0] pcm, logic last,
                           logic [4:0] cidx, logic signed [31:0] cval);
    chain_out_t r;
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 23) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.sample_in <= pcm;
    in_ch.block_end <= last;
    in_ch.coef_index <= cidx;
    in_ch.coef_value <= cval;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == OP_PROCESS) n_samples++;
    if (op == OP_COEF_WR) n_coef_writes++;
    if (chain_predict(op, pcm, last, cidx, cval, r)) expected_outputs.push_back(r);
  endtask

  task automatic send_sample(logic signed [15:0] pcm, logic last);
    send_item(OP_PROCESS, pcm, last, 5'($urandom), $urandom);
  endtask

  task automatic write_coef(logic [4:0] cidx, logic signed [31:0] cval);
    send_item(OP_COEF_WR, 16'($urandom), 1'($urandom), cidx, cval);
  endtask

  // Drop valid and wait until every expected result has come, then settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called while the chain is idle
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, d);
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic write_all_cfg(logic [4:0] en, logic [23:0] mix, logic [23:0] thr,
                               logic [23:0] mk, logic [23:0] envc, logic [23:0] atk,
                               logic [23:0] rel, logic [23:0] det);
    write_cfg(CFG_ENABLES, {19'd0, en});
    write_cfg(CFG_PUNCH_MIX, mix);
    write_cfg(CFG_THRESHOLD, thr);
    write_cfg(CFG_MAKEUP, mk);
    write_cfg(CFG_ENV_COEF, envc);
    write_cfg(CFG_ATTACK, atk);
    write_cfg(CFG_RELEASE, rel);
    write_cfg(CFG_DET_REL, det);
  endtask

  function automatic logic signed [31:0] rand_span(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Load a stable coefficient set: |a2| <= 0.5, |a1| <= 0.5
  task automatic load_stable_coefs();
    for (int k = 0; k < NUM_BIQUADS_DEF; k++) begin
      write_coef(5'(5 * k), rand_span(1 << 27));
      write_coef(5'(5 * k + 1), rand_span(1 << 26));
      write_coef(5'(5 * k + 2), rand_span(1 << 26));
      write_coef(5'(5 * k + 3), rand_span(1 << 26));
      write_coef(5'(5 * k + 4), rand_span(1 << 26));
    end
    write_coef(DC_POLE_WORD, $urandom_range(0, 1 << 27));
    write_coef(5'd31, $urandom);
  endtask

  function automatic logic signed [15:0] rand_pcm();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(rand_span(255));
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(rand_span(8000));
    endcase
  endfunction

  function automatic logic [23:0] rand_q24();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Reset with all inputs at known values
  task automatic test_reset();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_PROCESS;
    in_ch.sample_in <= '0;
    in_ch.block_end <= 1'b0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    foreach (coef_words[i]) coef_words[i] = '0;
    clear_chain_state();
    m_enables = '0;
    m_mix = 0;
    m_thr = 15938355;
    m_makeup = 1048576;
    m_env_c = 0;
    m_atk = 0;
    m_rel = 0;
    m_det_rel = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Passthrough with reset settings, field extremes, an unused op and a clear
  task automatic test_passthrough();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'shFFFF, 1'b0);
    send_item(OP_UNUSED, 16'sh7FFF, 1'b1, 5'd31, 32'sh7FFFFFFF);
    send_item(OP_CLEAR, 16'sh8000, 1'b0, 5'd0, 32'sh80000000);
    wait_idle();
  endtask

  // Load every coefficient word, then run the full chain on extremes
  task automatic test_full_chain_extremes();
    load_stable_coefs();
    write_coef(5'd31, 32'sh80000000);
    write_coef(5'd31, 32'sh7FFFFFFF);
    wait_idle();
    write_all_cfg(5'h1F, 24'h100000, 24'd1000000, 24'h100000, 24'h100000, 24'h400000,
                  24'h010000, 24'h080000);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b1);
    // Saturating coefficient in the bass stage
    write_coef(5'(5 * BQ_BASS), 32'sh7FFFFFFF);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_item(OP_CLEAR, 16'sh0, 1'b0, 5'd0, 32'sh0);
    send_sample(16'sh4000, 1'b1);
    send_item(OP_UNUSED, 16'sh0, 1'b0, 5'd0, 32'sh0);
    send_sample(16'shC000, 1'b1);
    wait_idle();
    // Tiny threshold and all-ones registers
    write_all_cfg(5'h1F, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  24'hFFFFFF, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh7FFF : 16'sh8000, i == 5);
    wait_idle();
  endtask

  // Long receiver hold-off while samples keep coming
  task automatic test_output_backpressure();
    write_all_cfg(5'h1F, 24'h080000, 24'd8000000, 24'h100000, 24'h200000, 24'h800000,
                  24'h020000, 24'h040000);
    no_idle = 1'b1;
    hold_request++;
    for (int i = 0; i < 40; i++) send_sample(rand_pcm(), i % 10 == 9);
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Random content in phases, each under a fresh configuration
  task automatic test_random_phases(int n_phases, int per_phase);
    logic [4:0] en;
    logic [23:0] thr, mk;
    for (int p = 0; p < n_phases; p++) begin
      en = 5'($urandom);
      if ($urandom_range(0, 9) != 0) en[EN_ACTIVE] = 1'b1;
      if (p == 0) en = 5'h1F;
      thr = (p == 1) ? 24'd1 : (p == 2) ? 24'hFFFFFF : 24'($urandom_range(1, 24'hFFFFFF));
      mk = $urandom_range(0, 3) == 0 ? rand_q24() : 24'($urandom_range(24'h80000, 24'h200000));
      if (p == 3) mk = 24'd0;
      write_all_cfg(en, rand_q24(), thr, mk, rand_q24(), rand_q24(), rand_q24(), rand_q24());
      if (p % 3 == 0) load_stable_coefs();
      no_idle = (p % 4 == 1);
      for (int i = 0; i < per_phase; i++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) send_item(OP_CLEAR, 16'($urandom), 1'($urandom), 5'($urandom), $urandom);
        else if (pick < 3) write_coef(5'($urandom), $urandom);
        else if (pick < 5) write_coef(5'($urandom), rand_span(1 << 26));
        else if (pick < 6) send_item(OP_UNUSED, 16'($urandom), 1'($urandom), 5'($urandom),
                                     $urandom);
        else send_sample(rand_pcm(), $urandom_range(0, 15) == 0);
        // Sender pause until the chain has drained
        if (i == per_phase / 2 && p % 5 == 2) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (expected_outputs.size() != 0) @(posedge clk_i);
        end
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    errors = 0;
    n_samples = 0;
    n_results = 0;
    n_cfg_writes = 0;
    n_coef_writes = 0;
    no_idle = 1'b0;
    hold_request = 0;
    hold_taken = 0;
    test_reset();
    test_passthrough();
    test_full_chain_extremes();
    test_output_backpressure();
    test_random_phases(13, 130);
    // Leftover expectations count as failures
    if (expected_outputs.size() != 0) begin
      errors++;
      $display("%0t: pending results expected 0 actual %0d", $time,
               expected_outputs.size());
    end
    $display("Covered %0d samples, %0d results, %0d coefficient writes, %0d register writes",
             n_samples, n_results, n_coef_writes, n_cfg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/aelc_pkg.sv
design/aelc_if.sv
design/aelc_div.sv
design/audio_eq_limiter_chain.sv
design/aelc_checker.sv
bench/tb.sv
